@@ hw/rtl/iqafd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqafd_pkg
// Shared widths, filter coefficients, cordic angle table and multiply-
// accumulate request type for the I/Q AM/FM demodulator.
// ----------------------------------------------------------------------------
package iqafd_pkg;

    // field widths
    localparam int IQ_W        = 8;
    localparam int AUDIO_W     = 16;
    localparam int SMOOTH_W    = 18;
    localparam int PHASE_W     = 16;

    // multiply-accumulate datapath
    localparam int MAC_A_W     = 18;
    localparam int MAC_B_W     = 17;
    localparam int MAC_ACC_W   = 36;
    localparam int FRAC_BITS   = 15;
    localparam int ROUND_BIAS  = 16384;

    // filter and discriminator coefficients, Q.15
    localparam int COEF_OLD    = 29491;
    localparam int COEF_NEW    = 3277;
    localparam int HALF_PI_Q15 = 51472;

    // square root unit
    localparam int SQRT_IN_W   = 32;
    localparam int SQRT_OUT_W  = 16;

    // cordic unit
    localparam int CORDIC_XY_W          = 27;
    localparam int CORDIC_Z_W           = 33;
    localparam int CORDIC_PRESHIFT      = 16;
    localparam int ATAN_W               = 30;
    localparam int ATAN_TABLE_LEN       = 24;
    localparam int STEP_W               = 5;
    localparam int CORDIC_STEPS_DEFAULT = 16;

    // operations of the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        MAC_IDLE,
        MAC_LOAD,
        MAC_LOAD_RND,
        MAC_ACC
    } mac_op_t;

    typedef struct packed {
        mac_op_t                    op;
        logic signed [MAC_A_W-1:0]  a;
        logic signed [MAC_B_W-1:0]  b;
    } mac_req_t;

    // atan(2^-k) as a binary angle, 2^32 units per turn
    function automatic logic [ATAN_W-1:0] atan_angle(input logic [STEP_W-1:0] k);
        logic [ATAN_W-1:0] ang;
        case (k)
            5'd0:    ang = 30'd536870912;
            5'd1:    ang = 30'd316933406;
            5'd2:    ang = 30'd167458907;
            5'd3:    ang = 30'd85004756;
            5'd4:    ang = 30'd42667331;
            5'd5:    ang = 30'd21354465;
            5'd6:    ang = 30'd10679838;
            5'd7:    ang = 30'd5340245;
            5'd8:    ang = 30'd2670163;
            5'd9:    ang = 30'd1335087;
            5'd10:   ang = 30'd667544;
            5'd11:   ang = 30'd333772;
            5'd12:   ang = 30'd166886;
            5'd13:   ang = 30'd83443;
            5'd14:   ang = 30'd41722;
            5'd15:   ang = 30'd20861;
            5'd16:   ang = 30'd10430;
            5'd17:   ang = 30'd5215;
            5'd18:   ang = 30'd2608;
            5'd19:   ang = 30'd1304;
            5'd20:   ang = 30'd652;
            5'd21:   ang = 30'd326;
            5'd22:   ang = 30'd163;
            5'd23:   ang = 30'd81;
            default: ang = '0;
        endcase
        return ang;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/iqafd_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqafd_mac
// Shared multiply-accumulate unit: one signed multiplier feeding a
// registered accumulator, optionally preloaded with the Q.15 rounding bias.
// ----------------------------------------------------------------------------
module iqafd_mac (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire iqafd_pkg::mac_req_t                    req,
    output logic signed [iqafd_pkg::MAC_ACC_W-1:0]      acc
);

    localparam int PROD_W = iqafd_pkg::MAC_A_W + iqafd_pkg::MAC_B_W;

    logic signed [PROD_W-1:0]                   prod;
    logic signed [iqafd_pkg::MAC_ACC_W-1:0]     prod_ext;
    logic signed [iqafd_pkg::MAC_ACC_W-1:0]     acc_reg;
    logic signed [iqafd_pkg::MAC_ACC_W-1:0]     acc_next;

    // single multiplier
    assign prod     = req.a * req.b;
    assign prod_ext = {{(iqafd_pkg::MAC_ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

    // accumulator update
    always_comb
    begin
        case (req.op)
            iqafd_pkg::MAC_LOAD:
                acc_next = prod_ext;
            iqafd_pkg::MAC_LOAD_RND:
                acc_next = prod_ext
                         + iqafd_pkg::MAC_ACC_W'(iqafd_pkg::ROUND_BIAS);
            iqafd_pkg::MAC_ACC:
                acc_next = acc_reg + prod_ext;
            default:
                acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

@@ hw/rtl/iqafd_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqafd_isqrt
// Digit-by-digit integer square root, one result bit per cycle, giving
// floor(sqrt(value)) of a 32-bit operand.
// ----------------------------------------------------------------------------
module iqafd_isqrt (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic [iqafd_pkg::SQRT_IN_W-1:0]        operand,
    output logic                                        done,
    output logic [iqafd_pkg::SQRT_OUT_W-1:0]            root
);

    localparam int W = iqafd_pkg::SQRT_IN_W;

    logic           run_reg;
    logic           run_next;
    logic           done_reg;
    logic           done_next;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   rem_next;
    logic [W-1:0]   r_reg;
    logic [W-1:0]   r_next;
    logic [W-1:0]   bit_reg;
    logic [W-1:0]   bit_next;
    logic [W:0]     trial;

    assign trial = {1'b0, r_reg} + {1'b0, bit_reg};

    // one root bit per cycle
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            run_next = 1'b1;
            rem_next = operand;
            r_next   = '0;
            bit_next = W'(1) << (W - 2);
        end
        else if (run_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = W'({1'b0, rem_reg} - trial);
                r_next   = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            r_reg    <= '0;
            bit_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            rem_reg  <= rem_next;
            r_reg    <= r_next;
            bit_reg  <= bit_next;
        end
    end

    assign done = done_reg;
    assign root = r_reg[iqafd_pkg::SQRT_OUT_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/iqafd_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iqafd_cordic
// Vectoring cordic, one micro-rotation per cycle, returning the phase of
// an I/Q pair as a 16-bit binary angle (65536 units per turn).
// ----------------------------------------------------------------------------
module iqafd_cordic #(
    parameter int STEPS = iqafd_pkg::CORDIC_STEPS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [iqafd_pkg::IQ_W-1:0]      x_in,
    input  wire logic signed [iqafd_pkg::IQ_W-1:0]      y_in,
    output logic                                        done,
    output logic [iqafd_pkg::PHASE_W-1:0]               phase
);

    localparam int XY_W      = iqafd_pkg::CORDIC_XY_W;
    localparam int Z_W       = iqafd_pkg::CORDIC_Z_W;
    localparam int PW        = iqafd_pkg::PHASE_W;
    localparam int RUN_STEPS = (STEPS < iqafd_pkg::ATAN_TABLE_LEN) ? STEPS
                                                                   : iqafd_pkg::ATAN_TABLE_LEN;
    localparam logic [iqafd_pkg::STEP_W-1:0] LAST_STEP = iqafd_pkg::STEP_W'(RUN_STEPS - 1);

    logic                               run_reg;
    logic                               run_next;
    logic                               done_reg;
    logic                               done_next;
    logic                               zero_reg;
    logic                               zero_next;
    logic [iqafd_pkg::STEP_W-1:0]       k_reg;
    logic [iqafd_pkg::STEP_W-1:0]       k_next;
    logic signed [XY_W-1:0]             x_reg;
    logic signed [XY_W-1:0]             x_next;
    logic signed [XY_W-1:0]             y_reg;
    logic signed [XY_W-1:0]             y_next;
    logic signed [Z_W-1:0]              z_reg;
    logic signed [Z_W-1:0]              z_next;
    logic [PW-1:0]                      phase_reg;
    logic [PW-1:0]                      phase_next;
    logic signed [XY_W-1:0]             x_load;
    logic signed [XY_W-1:0]             y_load;
    logic signed [XY_W-1:0]             dx;
    logic signed [XY_W-1:0]             dy;
    logic signed [Z_W-1:0]              ang;
    logic signed [Z_W-1:0]              z_round;

    // inputs scaled by 2^16
    assign x_load = {{(XY_W-iqafd_pkg::IQ_W-iqafd_pkg::CORDIC_PRESHIFT){x_in[iqafd_pkg::IQ_W-1]}},
                     x_in, {iqafd_pkg::CORDIC_PRESHIFT{1'b0}}};
    assign y_load = {{(XY_W-iqafd_pkg::IQ_W-iqafd_pkg::CORDIC_PRESHIFT){y_in[iqafd_pkg::IQ_W-1]}},
                     y_in, {iqafd_pkg::CORDIC_PRESHIFT{1'b0}}};

    // shared shifters and angle lookup for the current step
    assign dx  = y_reg >>> k_reg;
    assign dy  = x_reg >>> k_reg;
    assign ang = $signed({{(Z_W-iqafd_pkg::ATAN_W){1'b0}}, iqafd_pkg::atan_angle(k_reg)});

    // round the 32-bit angle to 16 bits
    assign z_round = z_next + Z_W'(1 << (PW - 1));

    always_comb
    begin
        run_next   = run_reg;
        done_next  = 1'b0;
        zero_next  = zero_reg;
        k_next     = k_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        phase_next = phase_reg;
        if (start)
        begin
            run_next  = 1'b1;
            zero_next = (x_in == '0) && (y_in == '0);
            k_next    = '0;
            // left half plane: rotate by pi first
            if (x_in[iqafd_pkg::IQ_W-1])
            begin
                x_next = -x_load;
                y_next = -y_load;
                z_next = Z_W'(64'd1 << (2 * PW - 1));
            end
            else
            begin
                x_next = x_load;
                y_next = y_load;
                z_next = '0;
            end
        end
        else if (run_reg)
        begin
            if (!y_reg[XY_W-1])
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + ang;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - ang;
            end
            k_next = k_reg + 1'b1;
            if (k_reg == LAST_STEP)
            begin
                run_next   = 1'b0;
                done_next  = 1'b1;
                // zero vector has phase zero
                phase_next = zero_reg ? '0 : z_round[2*PW-1:PW];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            zero_reg  <= 1'b0;
            k_reg     <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            phase_reg <= '0;
        end
        else
        begin
            run_reg   <= run_next;
            done_reg  <= done_next;
            zero_reg  <= zero_next;
            k_reg     <= k_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            phase_reg <= phase_next;
        end
    end

    assign done  = done_reg;
    assign phase = phase_reg;

endmodule
`default_nettype wire

@@ hw/rtl/iq_am_fm_demodulator_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iq_am_fm_demodulator_unit
// AM envelope / FM phase discriminator demodulator for 8-bit I/Q pairs,
// producing one saturated Q1.15 audio item per input item.
// ----------------------------------------------------------------------------
// The block takes one I/Q item at a time and holds in_stall high until its
// audio item has been computed. In FM mode (mode bit written as 1) the cordic
// unit first runs CORDIC_STEPS micro-rotations, but never more than 24,
// followed by one discriminator multiply, two filter multiply-accumulates
// on the shared multiplier and the output update. In AM mode the steps are
// two multiplies for I^2 + Q^2, a square root start step, the bit-serial
// square root, then the two filter steps and the output update. in_stall
// drops as the audio item is registered, so a new input item is taken only
// once the block is through with the last one.
// A finished audio item sits in an output register, so the next input item is
// taken while it waits; a new result is held back only while that register
// is still full. block_start clears the stored phase in either mode. There is
// no clearing pass after reset.
// ----------------------------------------------------------------------------
module iq_am_fm_demodulator_unit #(
    parameter int CORDIC_STEPS = iqafd_pkg::CORDIC_STEPS_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_wr_en,
    input  wire logic                                   cfg_wr_data,
    // input items
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic signed [iqafd_pkg::IQ_W-1:0]      in_phase,
    input  wire logic signed [iqafd_pkg::IQ_W-1:0]      quadrature,
    input  wire logic                                   block_start,
    // output items
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic signed [iqafd_pkg::AUDIO_W-1:0]        audio
);

    localparam int SW = iqafd_pkg::SMOOTH_W;
    localparam int AW = iqafd_pkg::AUDIO_W;
    localparam int PW = iqafd_pkg::PHASE_W;
    localparam int BW = iqafd_pkg::MAC_B_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_I,
        ST_SQ_Q,
        ST_SQRT_GO,
        ST_SQRT_RUN,
        ST_CORDIC_RUN,
        ST_HALF,
        ST_LP_OLD,
        ST_LP_NEW,
        ST_FINISH
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic                               mode_reg;
    logic                               mode_next;
    logic signed [iqafd_pkg::IQ_W-1:0]  i_reg;
    logic signed [iqafd_pkg::IQ_W-1:0]  i_next;
    logic signed [iqafd_pkg::IQ_W-1:0]  q_reg;
    logic signed [iqafd_pkg::IQ_W-1:0]  q_next;
    logic [PW-1:0]                      prev_phase_reg;
    logic [PW-1:0]                      prev_phase_next;
    logic signed [SW-1:0]               am_smooth_reg;
    logic signed [SW-1:0]               am_smooth_next;
    logic signed [SW-1:0]               fm_smooth_reg;
    logic signed [SW-1:0]               fm_smooth_next;
    logic signed [SW-1:0]               new_val_reg;
    logic signed [SW-1:0]               new_val_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [AW-1:0]               audio_reg;
    logic signed [AW-1:0]               audio_next;

    logic                               in_fire;
    logic                               out_free;
    iqafd_pkg::mac_req_t                mac_req;
    logic signed [iqafd_pkg::MAC_ACC_W-1:0] mac_acc;
    logic signed [SW-1:0]               acc_q15;
    logic                               sqrt_start;
    logic [iqafd_pkg::SQRT_IN_W-1:0]    sqrt_operand;
    logic                               sqrt_done;
    logic [iqafd_pkg::SQRT_OUT_W-1:0]   sqrt_root;
    logic                               cordic_start;
    logic                               cordic_done;
    logic [PW-1:0]                      cordic_phase;
    logic [PW-1:0]                      phase_step;
    logic signed [AW+3:0]               am_scaled;
    logic signed [AW-1:0]               am_audio;
    logic signed [AW-1:0]               fm_audio;

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign audio     = audio_reg;

    // shared multiply-accumulate
    iqafd_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mac_req),
        .acc   (mac_acc)
    );

    // accumulator scaled back to Q.15 with floor
    assign acc_q15 = mac_acc[iqafd_pkg::FRAC_BITS+SW-1:iqafd_pkg::FRAC_BITS];

    // envelope square root of (I^2 + Q^2) << 16
    assign sqrt_start   = (state_reg == ST_SQRT_GO);
    assign sqrt_operand = {mac_acc[iqafd_pkg::SQRT_IN_W-iqafd_pkg::SQRT_OUT_W-1:0],
                           {iqafd_pkg::SQRT_OUT_W{1'b0}}};

    iqafd_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_operand),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // phase of the I/Q pair
    assign cordic_start = in_fire && mode_reg;

    iqafd_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .x_in  (in_phase),
        .y_in  (quadrature),
        .done  (cordic_done),
        .phase (cordic_phase)
    );

    // wrapped phase step
    assign phase_step = cordic_phase - prev_phase_reg;

    // multiplier operands per step
    always_comb
    begin
        mac_req.op = iqafd_pkg::MAC_IDLE;
        mac_req.a  = '0;
        mac_req.b  = '0;
        case (state_reg)
            ST_SQ_I:
            begin
                mac_req.op = iqafd_pkg::MAC_LOAD;
                mac_req.a  = iqafd_pkg::MAC_A_W'(i_reg);
                mac_req.b  = BW'(i_reg);
            end
            ST_SQ_Q:
            begin
                mac_req.op = iqafd_pkg::MAC_ACC;
                mac_req.a  = iqafd_pkg::MAC_A_W'(q_reg);
                mac_req.b  = BW'(q_reg);
            end
            ST_HALF:
            begin
                mac_req.op = iqafd_pkg::MAC_LOAD_RND;
                mac_req.a  = iqafd_pkg::MAC_A_W'($signed(phase_step));
                mac_req.b  = BW'(iqafd_pkg::HALF_PI_Q15);
            end
            ST_LP_OLD:
            begin
                mac_req.op = iqafd_pkg::MAC_LOAD_RND;
                mac_req.a  = mode_reg ? fm_smooth_reg : am_smooth_reg;
                mac_req.b  = BW'(iqafd_pkg::COEF_OLD);
            end
            ST_LP_NEW:
            begin
                mac_req.op = iqafd_pkg::MAC_ACC;
                mac_req.a  = new_val_reg;
                mac_req.b  = BW'(iqafd_pkg::COEF_NEW);
            end
            default:
            begin
                mac_req.op = iqafd_pkg::MAC_IDLE;
            end
        endcase
    end

    // output mapping and saturation
    assign am_scaled = {{2{acc_q15[SW-1]}}, acc_q15[SW-2:0], 1'b0}
                     - (AW+4)'(1 << (AW - 1));

    always_comb
    begin
        if (am_scaled > (AW+4)'(32767))
        begin
            am_audio = AW'(32767);
        end
        else if (am_scaled < -(AW+4)'(32768))
        begin
            am_audio = -AW'(32768);
        end
        else
        begin
            am_audio = am_scaled[AW-1:0];
        end

        if (acc_q15 > SW'(32767))
        begin
            fm_audio = AW'(32767);
        end
        else if (acc_q15 < -SW'(32768))
        begin
            fm_audio = -AW'(32768);
        end
        else
        begin
            fm_audio = acc_q15[AW-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        i_next          = i_reg;
        q_next          = q_reg;
        prev_phase_next = prev_phase_reg;
        am_smooth_next  = am_smooth_reg;
        fm_smooth_next  = fm_smooth_reg;
        new_val_next    = new_val_reg;
        out_valid_next  = out_valid_reg;
        audio_next      = audio_reg;

        if (cfg_wr_en)
        begin
            mode_next = cfg_wr_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    i_next = in_phase;
                    q_next = quadrature;
                    if (block_start)
                    begin
                        prev_phase_next = '0;
                    end
                    state_next = mode_reg ? ST_CORDIC_RUN : ST_SQ_I;
                end
            end
            ST_SQ_I:
            begin
                state_next = ST_SQ_Q;
            end
            ST_SQ_Q:
            begin
                state_next = ST_SQRT_GO;
            end
            ST_SQRT_GO:
            begin
                state_next = ST_SQRT_RUN;
            end
            ST_SQRT_RUN:
            begin
                if (sqrt_done)
                begin
                    new_val_next = SW'(sqrt_root);
                    state_next   = ST_LP_OLD;
                end
            end
            ST_CORDIC_RUN:
            begin
                if (cordic_done)
                begin
                    state_next = ST_HALF;
                end
            end
            ST_HALF:
            begin
                state_next = ST_LP_OLD;
            end
            ST_LP_OLD:
            begin
                // phase step scaled by pi/2 is in the accumulator now
                if (mode_reg)
                begin
                    new_val_next = acc_q15;
                end
                state_next = ST_LP_NEW;
            end
            ST_LP_NEW:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (mode_reg)
                    begin
                        fm_smooth_next  = acc_q15;
                        prev_phase_next = cordic_phase;
                        audio_next      = fm_audio;
                    end
                    else
                    begin
                        am_smooth_next = acc_q15;
                        audio_next     = am_audio;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= 1'b0;
            prev_phase_reg <= '0;
            am_smooth_reg  <= '0;
            fm_smooth_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            prev_phase_reg <= prev_phase_next;
            am_smooth_reg  <= am_smooth_next;
            fm_smooth_reg  <= fm_smooth_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        q_reg       <= q_next;
        new_val_reg <= new_val_next;
        audio_reg   <= audio_next;
    end

endmodule
`default_nettype wire
